// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the feedback delay core modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SFD_ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define SFD_ASSERT_IMPL(lbl, pre, post, msg) `SFD_ASSERT_PROP(lbl, (pre) |-> (post), msg)

// Next-cycle implication.
`define SFD_ASSERT_NEXT(lbl, pre, post, msg) `SFD_ASSERT_PROP(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/core/sfd_pkg.sv =====
// Shared constants, command and status types, and arithmetic helpers for
// the stereo fractional feedback delay core. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam int DELAY_DEPTH = 65536;
    localparam int SAMPLE_BITS = 24;

    localparam int ADDR_W    = $clog2(DELAY_DEPTH);
    localparam int DELAY_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = DELAY_W - FRAC_BITS;
    localparam int GAIN_W    = 16;
    localparam int COEF_W    = 17;

    localparam int MUL_A_W = DELAY_W + 1;
    localparam int MUL_B_W = COEF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W   = PROD_W - FRAC_BITS;
    localparam int NS_W    = RND_W + 1;

    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = INT_BITS / MOD_DIGIT;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ADDR_W:0]       DEPTH_EXT = (ADDR_W + 1)'(DELAY_DEPTH);
    localparam logic [ADDR_W-1:0]     ADDR_LAST = ADDR_W'(DELAY_DEPTH - 1);
    localparam logic [COEF_W-1:0]     ONE_Q16   = COEF_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0]     HALF_Q16  = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [DELAY_W-1:0]    TARGET_RESET = 32'd1572864000;
    localparam logic [GAIN_W-1:0]     GAIN_RESET   = 16'd32768;
    localparam logic [COEF_W-1:0]     MIX_RESET    = 17'd32768;
    localparam logic [COEF_W-1:0]     GLIDE_RESET  = 17'd66;

    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(RND_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO =
        {{(RND_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_DELAY  = 2'd0,
        CFG_FEEDBACK_GAIN = 2'd1,
        CFG_WET_MIX       = 2'd2,
        CFG_GLIDE_COEFF   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SMOOTH,
        MUL_AL,
        MUL_BL,
        MUL_AR,
        MUL_BR,
        MUL_FBL,
        MUL_FBR,
        MUL_DRYL,
        MUL_DRYR,
        MUL_WETL,
        MUL_WETR
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_SMOOTH,
        CAP_WL,
        CAP_WR,
        CAP_FBL,
        CAP_FBR,
        CAP_OUTL,
        CAP_OUTR
    } cap_op_t;

    typedef struct packed {
        logic                  en;
        cfg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic    clr_step;
        logic    in_load;
        logic    store_we;
        logic    mod_step;
        logic    mod_first;
        logic    rd_en;
        logic    rd_sel;
        logic    a_load;
        logic    wp_inc;
        mul_op_t mul_op;
        acc_op_t acc_op;
        cap_op_t cap_op;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } status_t;

    // Drops 16 fraction bits, rounding half up.
    function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + $signed(HALF_Q16);
        return t[PROD_W-1:FRAC_BITS];
    endfunction

    // Clamps to the signed sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [RND_W-1:0] v
    );
        logic signed [RND_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end
        else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        else begin
            c = v;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for both delay stores.
`timescale 1ns / 1ps
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sfd_datapath.sv =====
// Datapath of the feedback delay core: configuration registers, delay
// smoother, address arithmetic, shared multiply-accumulate, both stores and
// the output register. Depends on sfd_pkg and sfd_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfd_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire sfd_pkg::cfg_wr_t                       cfg,
    input  wire sfd_pkg::cmd_t                          cmd,
    output sfd_pkg::status_t                            status,
    input  wire logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_in,
    input  wire logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_in,
    input  wire logic                                   out_ready,
    output logic                                        out_valid,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      left_out,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      right_out
);

    logic [sfd_pkg::DELAY_W-1:0] target_reg;
    logic [sfd_pkg::GAIN_W-1:0]  gain_reg;
    logic [sfd_pkg::COEF_W-1:0]  mix_reg;
    logic [sfd_pkg::COEF_W-1:0]  glide_reg;

    logic [sfd_pkg::DELAY_W-1:0]  s_reg;
    logic [sfd_pkg::DELAY_W-1:0]  s_next;
    logic [sfd_pkg::ADDR_W-1:0]   wp_reg;
    logic [sfd_pkg::ADDR_W-1:0]   clr_addr_reg;
    logic [sfd_pkg::ADDR_W-1:0]   rem_reg;
    logic [sfd_pkg::ADDR_W-1:0]   rem_next;
    logic [sfd_pkg::INT_BITS-1:0] sh_reg;
    logic [sfd_pkg::INT_BITS-1:0] sh_next;

    logic signed [sfd_pkg::SAMPLE_BITS-1:0] dry_l_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] dry_r_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] fbl_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] fbr_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] a_l_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] a_r_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] wl_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] wr_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] stage_l_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] stage_r_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] out_l_reg;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] out_r_reg;
    logic                                   out_valid_reg;

    logic signed [sfd_pkg::PROD_W-1:0]  prod_reg;
    logic signed [sfd_pkg::PROD_W-1:0]  acc_reg;
    logic signed [sfd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [sfd_pkg::MUL_B_W-1:0] mul_b;

    logic [sfd_pkg::COEF_W-1:0]    glide_eff;
    logic [sfd_pkg::COEF_W-1:0]    mix_eff;
    logic [sfd_pkg::COEF_W-1:0]    dry_share;
    logic [sfd_pkg::FRAC_BITS-1:0] s_frac;
    logic [sfd_pkg::FRAC_BITS-1:0] f_frac;
    logic [sfd_pkg::COEF_W-1:0]    f_comp;

    logic [sfd_pkg::INT_BITS-1:0] mod_src;
    logic [sfd_pkg::ADDR_W:0]     mod_ext;
    logic [sfd_pkg::ADDR_W-1:0]   mod_r;

    logic [sfd_pkg::ADDR_W:0]   rd_diff;
    logic [sfd_pkg::ADDR_W:0]   rd_wrap;
    logic [sfd_pkg::ADDR_W-1:0] idx0;
    logic [sfd_pkg::ADDR_W-1:0] idx1;
    logic [sfd_pkg::ADDR_W-1:0] rd_addr;
    logic [sfd_pkg::ADDR_W-1:0] wr_addr;
    logic                       ram_we;

    logic signed [sfd_pkg::SAMPLE_BITS-1:0] wdata_l;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] wdata_r;
    logic [sfd_pkg::SAMPLE_BITS-1:0]        q_l;
    logic [sfd_pkg::SAMPLE_BITS-1:0]        q_r;

    logic signed [sfd_pkg::RND_W-1:0]       acc_rnd;
    logic signed [sfd_pkg::SAMPLE_BITS-1:0] acc_sat;
    logic signed [sfd_pkg::NS_W-1:0]        ns_wide;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= sfd_pkg::TARGET_RESET;
            gain_reg   <= sfd_pkg::GAIN_RESET;
            mix_reg    <= sfd_pkg::MIX_RESET;
            glide_reg  <= sfd_pkg::GLIDE_RESET;
        end
        else if (cfg.en)
        begin
            unique case (cfg.index)
                sfd_pkg::CFG_TARGET_DELAY:  target_reg <= cfg.data[sfd_pkg::DELAY_W-1:0];
                sfd_pkg::CFG_FEEDBACK_GAIN: gain_reg   <= cfg.data[sfd_pkg::GAIN_W-1:0];
                sfd_pkg::CFG_WET_MIX:       mix_reg    <= cfg.data[sfd_pkg::COEF_W-1:0];
                sfd_pkg::CFG_GLIDE_COEFF:   glide_reg  <= cfg.data[sfd_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign glide_eff = (glide_reg > sfd_pkg::ONE_Q16) ? sfd_pkg::ONE_Q16 : glide_reg;
    assign mix_eff   = (mix_reg > sfd_pkg::ONE_Q16) ? sfd_pkg::ONE_Q16 : mix_reg;
    assign dry_share = sfd_pkg::ONE_Q16 - mix_eff;

    // The delay integer part is reduced modulo the depth, four bits per mod_step.
    always_comb
    begin
        mod_src = cmd.mod_first ? s_reg[sfd_pkg::DELAY_W-1:sfd_pkg::FRAC_BITS] : sh_reg;
        mod_r   = cmd.mod_first ? '0 : rem_reg;
        mod_ext = '0;
        for (int k = 0; k < sfd_pkg::MOD_DIGIT; k++)
        begin
            mod_ext = {mod_r, mod_src[sfd_pkg::INT_BITS-1-k]};
            if (mod_ext >= sfd_pkg::DEPTH_EXT)
            begin
                mod_ext = mod_ext - sfd_pkg::DEPTH_EXT;
            end
            mod_r = mod_ext[sfd_pkg::ADDR_W-1:0];
        end
        rem_next = mod_r;
        sh_next  = mod_src << sfd_pkg::MOD_DIGIT;
    end

    // Read position: the write pointer minus the reduced delay rounded up, wrapped.
    assign s_frac  = s_reg[sfd_pkg::FRAC_BITS-1:0];
    assign f_frac  = ~s_frac + 1'b1;
    assign f_comp  = sfd_pkg::ONE_Q16 - {1'b0, f_frac};
    assign rd_diff = {1'b0, wp_reg} - {1'b0, rem_reg}
                     - (sfd_pkg::ADDR_W + 1)'(s_frac != '0);
    assign rd_wrap = rd_diff + sfd_pkg::DEPTH_EXT;
    assign idx0    = rd_diff[sfd_pkg::ADDR_W] ? rd_wrap[sfd_pkg::ADDR_W-1:0]
                                              : rd_diff[sfd_pkg::ADDR_W-1:0];
    assign idx1    = (idx0 == sfd_pkg::ADDR_LAST) ? '0 : idx0 + 1'b1;
    assign rd_addr = cmd.rd_sel ? idx1 : idx0;

    // Store writes: input plus the previous feedback, saturated; zero while clearing.
    assign wdata_l = cmd.clr_step ? '0 : sfd_pkg::sat_sample(
                         sfd_pkg::RND_W'(dry_l_reg) + sfd_pkg::RND_W'(fbl_reg));
    assign wdata_r = cmd.clr_step ? '0 : sfd_pkg::sat_sample(
                         sfd_pkg::RND_W'(dry_r_reg) + sfd_pkg::RND_W'(fbr_reg));
    assign wr_addr = cmd.clr_step ? clr_addr_reg : wp_reg;
    assign ram_we  = cmd.clr_step | cmd.store_we;

    sfd_ram #(
        .WIDTH(sfd_pkg::SAMPLE_BITS),
        .DEPTH(sfd_pkg::DELAY_DEPTH)
    ) u_left_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_addr),
        .wdata(wdata_l),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(q_l)
    );

    sfd_ram #(
        .WIDTH(sfd_pkg::SAMPLE_BITS),
        .DEPTH(sfd_pkg::DELAY_DEPTH)
    ) u_right_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_addr),
        .wdata(wdata_r),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(q_r)
    );

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            sfd_pkg::MUL_SMOOTH:
            begin
                mul_a = $signed({1'b0, s_reg}) - $signed({1'b0, target_reg});
                mul_b = $signed({1'b0, glide_eff});
            end
            sfd_pkg::MUL_AL:
            begin
                mul_a = sfd_pkg::MUL_A_W'(a_l_reg);
                mul_b = $signed({1'b0, f_comp});
            end
            sfd_pkg::MUL_BL:
            begin
                mul_a = sfd_pkg::MUL_A_W'($signed(q_l));
                mul_b = $signed({2'b00, f_frac});
            end
            sfd_pkg::MUL_AR:
            begin
                mul_a = sfd_pkg::MUL_A_W'(a_r_reg);
                mul_b = $signed({1'b0, f_comp});
            end
            sfd_pkg::MUL_BR:
            begin
                mul_a = sfd_pkg::MUL_A_W'($signed(q_r));
                mul_b = $signed({2'b00, f_frac});
            end
            sfd_pkg::MUL_FBL:
            begin
                mul_a = sfd_pkg::MUL_A_W'(wl_reg);
                mul_b = $signed({2'b00, gain_reg});
            end
            sfd_pkg::MUL_FBR:
            begin
                mul_a = sfd_pkg::MUL_A_W'(wr_reg);
                mul_b = $signed({2'b00, gain_reg});
            end
            sfd_pkg::MUL_DRYL:
            begin
                mul_a = sfd_pkg::MUL_A_W'(dry_l_reg);
                mul_b = $signed({1'b0, dry_share});
            end
            sfd_pkg::MUL_DRYR:
            begin
                mul_a = sfd_pkg::MUL_A_W'(dry_r_reg);
                mul_b = $signed({1'b0, dry_share});
            end
            sfd_pkg::MUL_WETL:
            begin
                mul_a = sfd_pkg::MUL_A_W'(wl_reg);
                mul_b = $signed({1'b0, mix_eff});
            end
            sfd_pkg::MUL_WETR:
            begin
                mul_a = sfd_pkg::MUL_A_W'(wr_reg);
                mul_b = $signed({1'b0, mix_eff});
            end
            default: ;
        endcase
    end

    // Rounded and saturated view of the accumulator, and the next delay.
    assign acc_rnd = sfd_pkg::round_q16(acc_reg);
    assign acc_sat = sfd_pkg::sat_sample(acc_rnd);
    assign ns_wide = $signed({{(sfd_pkg::NS_W - sfd_pkg::DELAY_W){1'b0}}, s_reg})
                     - sfd_pkg::NS_W'(acc_rnd);

    always_comb
    begin
        if (ns_wide[sfd_pkg::NS_W-1])
        begin
            s_next = '0;
        end
        else if (ns_wide[sfd_pkg::NS_W-2:sfd_pkg::DELAY_W] != '0)
        begin
            s_next = '1;
        end
        else
        begin
            s_next = ns_wide[sfd_pkg::DELAY_W-1:0];
        end
    end

    // Control state and state with defined reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg         <= sfd_pkg::TARGET_RESET;
            wp_reg        <= '0;
            clr_addr_reg  <= '0;
            fbl_reg       <= '0;
            fbr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cap_op == sfd_pkg::CAP_SMOOTH)
            begin
                s_reg <= s_next;
            end
            if (cmd.cap_op == sfd_pkg::CAP_FBL)
            begin
                fbl_reg <= acc_sat;
            end
            if (cmd.cap_op == sfd_pkg::CAP_FBR)
            begin
                fbr_reg <= acc_sat;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.wp_inc)
            begin
                wp_reg <= (wp_reg == sfd_pkg::ADDR_LAST) ? '0 : wp_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.acc_op)
            sfd_pkg::ACC_LOAD: acc_reg <= prod_reg;
            sfd_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default: ;
        endcase
        case (cmd.cap_op)
            sfd_pkg::CAP_WL:   wl_reg      <= acc_sat;
            sfd_pkg::CAP_WR:   wr_reg      <= acc_sat;
            sfd_pkg::CAP_OUTL: stage_l_reg <= acc_sat;
            sfd_pkg::CAP_OUTR: stage_r_reg <= acc_sat;
            default: ;
        endcase
        if (cmd.in_load)
        begin
            dry_l_reg <= left_in;
            dry_r_reg <= right_in;
        end
        if (cmd.mod_step)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
        if (cmd.a_load)
        begin
            a_l_reg <= $signed(q_l);
            a_r_reg <= $signed(q_r);
        end
        if (cmd.out_load)
        begin
            out_l_reg <= stage_l_reg;
            out_r_reg <= stage_r_reg;
        end
    end

    assign status.clr_last = (clr_addr_reg == sfd_pkg::ADDR_LAST);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

    `SFD_ASSERT_IMPL(a_rd_addr_in_range, cmd.rd_en, ({1'b0, rd_addr} < sfd_pkg::DEPTH_EXT), "store read address beyond depth")
    `SFD_ASSERT_NEXT(a_rem_in_range, cmd.mod_step, ({1'b0, rem_reg} < sfd_pkg::DEPTH_EXT), "delay remainder not reduced below depth")
    `SFD_ASSERT_IMPL(a_no_write_clash, cmd.store_we, !cmd.clr_step, "sample write during clearing pass")

endmodule

`default_nettype wire

// ===== rtl/core/sfd_ctrl.sv =====
// Controller of the feedback delay core: sequences the clearing pass, the
// per-item smoother, modulo, store reads and multiply schedule. Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sfd_pkg::status_t status,
    output sfd_pkg::cmd_t         cmd
);

    localparam int STATE_W = 21;

    typedef enum logic [STATE_W-1:0] {
        S_CLEAR = STATE_W'(1) << 0,
        S_IDLE  = STATE_W'(1) << 1,
        S_SMUL  = STATE_W'(1) << 2,
        S_SACC  = STATE_W'(1) << 3,
        S_SCAP  = STATE_W'(1) << 4,
        S_MOD   = STATE_W'(1) << 5,
        S_RD0   = STATE_W'(1) << 6,
        S_RD1   = STATE_W'(1) << 7,
        S_X0    = STATE_W'(1) << 8,
        S_X1    = STATE_W'(1) << 9,
        S_X2    = STATE_W'(1) << 10,
        S_X3    = STATE_W'(1) << 11,
        S_X4    = STATE_W'(1) << 12,
        S_X5    = STATE_W'(1) << 13,
        S_X6    = STATE_W'(1) << 14,
        S_X7    = STATE_W'(1) << 15,
        S_X8    = STATE_W'(1) << 16,
        S_X9    = STATE_W'(1) << 17,
        S_X10   = STATE_W'(1) << 18,
        S_X11   = STATE_W'(1) << 19,
        S_DONE  = STATE_W'(1) << 20
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [sfd_pkg::MOD_CNT_W-1:0]  mod_cnt_reg;
    logic [sfd_pkg::MOD_CNT_W-1:0]  mod_cnt_next;
    logic                           mod_last;

    assign mod_last = (mod_cnt_reg == sfd_pkg::MOD_CNT_W'(sfd_pkg::MOD_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            mod_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mod_cnt_reg <= mod_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mod_cnt_next = mod_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_op   = sfd_pkg::MUL_NONE;
        cmd.acc_op   = sfd_pkg::ACC_HOLD;
        cmd.cap_op   = sfd_pkg::CAP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
                if (in_valid)
                begin
                    state_next = S_SMUL;
                end
            end
            S_SMUL:
            begin
                cmd.mul_op   = sfd_pkg::MUL_SMOOTH;
                cmd.store_we = 1'b1;
                state_next   = S_SACC;
            end
            S_SACC:
            begin
                cmd.acc_op = sfd_pkg::ACC_LOAD;
                state_next = S_SCAP;
            end
            S_SCAP:
            begin
                cmd.cap_op = sfd_pkg::CAP_SMOOTH;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step  = 1'b1;
                cmd.mod_first = (mod_cnt_reg == '0);
                if (mod_last)
                begin
                    mod_cnt_next = '0;
                    state_next   = S_RD0;
                end
                else
                begin
                    mod_cnt_next = mod_cnt_reg + 1'b1;
                end
            end
            S_RD0:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 1'b1;
                cmd.a_load = 1'b1;
                state_next = S_X0;
            end
            S_X0:
            begin
                cmd.mul_op = sfd_pkg::MUL_AL;
                cmd.wp_inc = 1'b1;
                state_next = S_X1;
            end
            S_X1:
            begin
                cmd.mul_op = sfd_pkg::MUL_BL;
                cmd.acc_op = sfd_pkg::ACC_LOAD;
                state_next = S_X2;
            end
            S_X2:
            begin
                cmd.mul_op = sfd_pkg::MUL_AR;
                cmd.acc_op = sfd_pkg::ACC_ADD;
                state_next = S_X3;
            end
            S_X3:
            begin
                cmd.mul_op = sfd_pkg::MUL_BR;
                cmd.acc_op = sfd_pkg::ACC_LOAD;
                cmd.cap_op = sfd_pkg::CAP_WL;
                state_next = S_X4;
            end
            S_X4:
            begin
                cmd.mul_op = sfd_pkg::MUL_FBL;
                cmd.acc_op = sfd_pkg::ACC_ADD;
                state_next = S_X5;
            end
            S_X5:
            begin
                cmd.mul_op = sfd_pkg::MUL_DRYL;
                cmd.acc_op = sfd_pkg::ACC_LOAD;
                cmd.cap_op = sfd_pkg::CAP_WR;
                state_next = S_X6;
            end
            S_X6:
            begin
                cmd.mul_op = sfd_pkg::MUL_WETL;
                cmd.acc_op = sfd_pkg::ACC_LOAD;
                cmd.cap_op = sfd_pkg::CAP_FBL;
                state_next = S_X7;
            end
            S_X7:
            begin
                cmd.mul_op = sfd_pkg::MUL_FBR;
                cmd.acc_op = sfd_pkg::ACC_ADD;
                state_next = S_X8;
            end
            S_X8:
            begin
                cmd.mul_op = sfd_pkg::MUL_DRYR;
                cmd.acc_op = sfd_pkg::ACC_LOAD;
                cmd.cap_op = sfd_pkg::CAP_OUTL;
                state_next = S_X9;
            end
            S_X9:
            begin
                cmd.mul_op = sfd_pkg::MUL_WETR;
                cmd.acc_op = sfd_pkg::ACC_LOAD;
                cmd.cap_op = sfd_pkg::CAP_FBR;
                state_next = S_X10;
            end
            S_X10:
            begin
                cmd.acc_op = sfd_pkg::ACC_ADD;
                state_next = S_X11;
            end
            S_X11:
            begin
                cmd.cap_op = sfd_pkg::CAP_OUTR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    `SFD_ASSERT_NEXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "second transfer accepted while an item is in progress")
    `SFD_ASSERT_IMPL(a_out_load_free, cmd.out_load, status.out_free, "output register overwritten before its transfer")

endmodule

`default_nettype wire

// ===== rtl/core/stereo_fractional_feedback_delay_core.sv =====
// Top level of the stereo fractional feedback delay core.
// Instantiates sfd_ctrl and sfd_datapath; depends on sfd_pkg.
// Usage:
// Input channel: in_valid/in_ready with left_in and right_in, one stereo
// sample pair per transfer. Output channel: out_valid/out_ready with
// left_out and right_out, one mixed pair per input transfer, in order.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0 is the target delay, 1 the feedback
// gain, 2 the wet mix and 3 the glide coefficient. Write only while idle.
// A new item is taken only after the previous one has been loaded into the
// output register. The pace is set by the single shared multiplier, which
// runs eleven products per item, plus the stepwise delay modulo unit and
// the two reads of each store's one read port.
// After reset both 65536-entry stores are cleared one entry per cycle, and
// in_ready stays low until that pass ends; configuration writes are
// accepted during that pass. The result sits in an output register: the
// next input is taken while it waits, and a stalled receiver holds the
// core before its following result is loaded, without loss.
`timescale 1ns / 1ps
`default_nettype none

module stereo_fractional_feedback_delay_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_in,
    input  wire logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_in,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      left_out,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      right_out,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sfd_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]         cfg_data
);

    sfd_pkg::cfg_wr_t cfg;
    sfd_pkg::cmd_t    cmd;
    sfd_pkg::status_t status;

    assign cfg_ready = 1'b1;
    assign cfg.en    = cfg_valid;
    assign cfg.index = sfd_pkg::cfg_index_t'(cfg_index);
    assign cfg.data  = cfg_data;

    sfd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sfd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .left_in  (left_in),
        .right_in (right_in),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .left_out (left_out),
        .right_out(right_out)
    );

endmodule

`default_nettype wire
